/* sv/fpr_pkg.sv */
// Shared constants, codes, types and helpers for the fit-and-place rectangle block.
package fpr_pkg;

    localparam int SUBPIXEL_BITS = 6;
    localparam int COORD_BITS    = 24;
    localparam int ORIG_BITS     = COORD_BITS - 1;
    localparam int POS_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * ORIG_BITS;
    localparam int DIV_STAGES    = ORIG_BITS;

    localparam logic [2:0] MODE_ORIGINAL   = 3'd0;
    localparam logic [2:0] MODE_STRETCH    = 3'd1;
    localparam logic [2:0] MODE_SCALE      = 3'd2;
    localparam logic [2:0] MODE_STRETCH_DN = 3'd3;
    localparam logic [2:0] MODE_SCALE_DN   = 3'd4;

    localparam logic [3:0] PLACE_NW     = 4'd0;
    localparam logic [3:0] PLACE_NW_ALT = 4'd1;
    localparam logic [3:0] PLACE_N      = 4'd2;
    localparam logic [3:0] PLACE_NE     = 4'd3;
    localparam logic [3:0] PLACE_E      = 4'd4;
    localparam logic [3:0] PLACE_SE     = 4'd5;
    localparam logic [3:0] PLACE_S      = 4'd6;
    localparam logic [3:0] PLACE_SW     = 4'd7;
    localparam logic [3:0] PLACE_W      = 4'd8;
    localparam logic [3:0] PLACE_CENTER = 4'd9;

    typedef struct packed {
        logic [3:0]                   placement;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bw;
        logic signed [COORD_BITS-1:0] bh;
        logic [ORIG_BITS-1:0]         fix_w;
        logic [ORIG_BITS-1:0]         fix_h;
        logic                         use_div;
        logic                         div_to_h;
    } t_side;

    localparam logic [POS_BITS-1:0] POS_MASK = ~POS_BITS'((1 << SUBPIXEL_BITS) - 1);
    localparam logic [ORIG_BITS-1:0] ORIG_MASK = ~ORIG_BITS'((1 << SUBPIXEL_BITS) - 1);

endpackage

/* sv/fit_and_place_rect.sv */
// Top level of the fit-and-place rectangle block.
// Sizes content inside a bounding rectangle by a size policy and places it at one of nine
// anchors, all coordinates in subpixels and results aligned down to whole pixels. One beat
// is accepted per cycle while the output is not stalled; each result passes in order through
// the front registers, the one-bit-per-stage quotient pipeline of the aspect-ratio divider
// and the placement registers. The pipeline advances as a whole whenever the output
// register is empty or being taken, so a stalled output holds every stage in place.
module fit_and_place_rect import fpr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_mode,
    input  logic [3:0]                   i_placement,
    input  logic signed [COORD_BITS-1:0] i_bounds_x,
    input  logic signed [COORD_BITS-1:0] i_bounds_y,
    input  logic signed [COORD_BITS-1:0] i_bounds_w,
    input  logic signed [COORD_BITS-1:0] i_bounds_h,
    input  logic [ORIG_BITS-1:0]         i_orig_w,
    input  logic [ORIG_BITS-1:0]         i_orig_h,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [POS_BITS-1:0]   o_rect_x,
    output logic signed [POS_BITS-1:0]   o_rect_y,
    output logic [ORIG_BITS-1:0]         o_rect_w,
    output logic [ORIG_BITS-1:0]         o_rect_h
);

    logic                 adv;
    logic                 f_v, d_v;
    logic [ORIG_BITS-1:0] f_rem, f_low, f_den, d_quot;
    t_side                f_side, d_side;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    fpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_placement (i_placement),
        .i_bounds_x  (i_bounds_x),
        .i_bounds_y  (i_bounds_y),
        .i_bounds_w  (i_bounds_w),
        .i_bounds_h  (i_bounds_h),
        .i_orig_w    (i_orig_w),
        .i_orig_h    (i_orig_h),
        .o_valid     (f_v),
        .o_rem       (f_rem),
        .o_low       (f_low),
        .o_den       (f_den),
        .o_side      (f_side)
    );

    fpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_v),
        .i_rem   (f_rem),
        .i_low   (f_low),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_v),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    fpr_place u_place (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (d_v),
        .i_quot   (d_quot),
        .i_side   (d_side),
        .o_valid  (o_valid),
        .o_rect_x (o_rect_x),
        .o_rect_y (o_rect_y),
        .o_rect_w (o_rect_w),
        .o_rect_h (o_rect_h)
    );

`ifndef SYNTHESIS
    a_ready_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_pixel_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rect_x & ~POS_MASK) == '0 && (o_rect_y & ~POS_MASK) == '0 &&
                     (o_rect_w & ~ORIG_MASK) == '0 && (o_rect_h & ~ORIG_MASK) == '0))
        else $error("result not pixel aligned");

    a_stall_holds_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(d_v) && $stable(d_quot))
        else $error("divider moved during stall");
`endif

endmodule

/* sv/fpr_front.sv */
// Input capture, cross products and size policy decision.
module fpr_front import fpr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [2:0]                   i_mode,
    input  logic [3:0]                   i_placement,
    input  logic signed [COORD_BITS-1:0] i_bounds_x,
    input  logic signed [COORD_BITS-1:0] i_bounds_y,
    input  logic signed [COORD_BITS-1:0] i_bounds_w,
    input  logic signed [COORD_BITS-1:0] i_bounds_h,
    input  logic [ORIG_BITS-1:0]         i_orig_w,
    input  logic [ORIG_BITS-1:0]         i_orig_h,
    output logic                         o_valid,
    output logic [ORIG_BITS-1:0]         o_rem,
    output logic [ORIG_BITS-1:0]         o_low,
    output logic [ORIG_BITS-1:0]         o_den,
    output t_side                        o_side
);

    logic                         r0_v, r1_v, r2_v;
    logic [2:0]                   r0_mode, r1_mode;
    logic [3:0]                   r0_place, r1_place;
    logic signed [COORD_BITS-1:0] r0_bx, r0_by, r0_bw, r0_bh;
    logic signed [COORD_BITS-1:0] r1_bx, r1_by, r1_bw, r1_bh;
    logic [ORIG_BITS-1:0]         r0_ow, r0_oh, r1_ow, r1_oh;
    logic [PROD_BITS-1:0]         r1_pw, r1_ph;
    logic [PROD_BITS-1:0]         r2_num, n_num;
    logic [ORIG_BITS-1:0]         r2_den, n_den;
    t_side                        r2_side, n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_mode  <= i_mode;
            r0_place <= i_placement;
            r0_bx    <= i_bounds_x;
            r0_by    <= i_bounds_y;
            r0_bw    <= i_bounds_w;
            r0_bh    <= i_bounds_h;
            r0_ow    <= i_orig_w;
            r0_oh    <= i_orig_h;
            r1_mode  <= r0_mode;
            r1_place <= r0_place;
            r1_bx    <= r0_bx;
            r1_by    <= r0_by;
            r1_bw    <= r0_bw;
            r1_bh    <= r0_bh;
            r1_ow    <= r0_ow;
            r1_oh    <= r0_oh;
            r1_pw    <= PROD_BITS'(r0_ow) * PROD_BITS'(r0_bh[ORIG_BITS-1:0]);
            r1_ph    <= PROD_BITS'(r0_oh) * PROD_BITS'(r0_bw[ORIG_BITS-1:0]);
            r2_num   <= n_num;
            r2_den   <= n_den;
            r2_side  <= n_side;
        end
    end

    logic [ORIG_BITS-1:0] bwu, bhu;
    logic                 pos, w_bound;

    always_comb begin
        bwu     = r1_bw[ORIG_BITS-1:0];
        bhu     = r1_bh[ORIG_BITS-1:0];
        pos     = (r1_bw > 0) && (r1_bh > 0);
        w_bound = r1_pw > r1_ph;
        n_num   = '0;
        n_den   = ORIG_BITS'(1);
        n_side.placement = r1_place;
        n_side.bx        = r1_bx;
        n_side.by        = r1_by;
        n_side.bw        = r1_bw;
        n_side.bh        = r1_bh;
        n_side.fix_w     = r1_ow;
        n_side.fix_h     = r1_oh;
        n_side.use_div   = 1'b0;
        n_side.div_to_h  = 1'b0;
        if (!pos) begin
            n_side.fix_w = '0;
            n_side.fix_h = '0;
        end else begin
            case (r1_mode)
                MODE_STRETCH: begin
                    n_side.fix_w = bwu;
                    n_side.fix_h = bhu;
                end
                MODE_STRETCH_DN: begin
                    n_side.fix_w = (r1_ow < bwu) ? r1_ow : bwu;
                    n_side.fix_h = (r1_oh < bhu) ? r1_oh : bhu;
                end
                MODE_SCALE, MODE_SCALE_DN: begin
                    if (!(r1_mode == MODE_SCALE_DN && r1_ow <= bwu && r1_oh <= bhu)) begin
                        if (w_bound) begin
                            n_side.use_div  = 1'b1;
                            n_side.div_to_h = 1'b1;
                            n_side.fix_w    = bwu;
                            n_num           = r1_ph;
                            n_den           = r1_ow;
                        end else if (r1_oh == '0) begin
                            n_side.fix_w = '0;
                            n_side.fix_h = bhu;
                        end else begin
                            n_side.use_div = 1'b1;
                            n_side.fix_h   = bhu;
                            n_num          = r1_pw;
                            n_den          = r1_oh;
                        end
                    end
                end
                default: begin
                    n_side.fix_w = r1_ow;
                    n_side.fix_h = r1_oh;
                end
            endcase
        end
    end

    assign o_valid = r2_v;
    assign o_rem   = r2_num[PROD_BITS-1:ORIG_BITS];
    assign o_low   = r2_num[ORIG_BITS-1:0];
    assign o_den   = r2_den;
    assign o_side  = r2_side;

endmodule

/* sv/fpr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
module fpr_div import fpr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [ORIG_BITS-1:0] i_rem,
    input  logic [ORIG_BITS-1:0] i_low,
    input  logic [ORIG_BITS-1:0] i_den,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [ORIG_BITS-1:0] o_quot,
    output t_side                o_side
);

    logic                 p_v    [0:DIV_STAGES];
    logic [ORIG_BITS-1:0] p_rem  [0:DIV_STAGES];
    logic [ORIG_BITS-1:0] p_low  [0:DIV_STAGES];
    logic [ORIG_BITS-1:0] p_den  [0:DIV_STAGES];
    t_side                p_side [0:DIV_STAGES];

    assign p_v[0]    = i_valid;
    assign p_rem[0]  = i_rem;
    assign p_low[0]  = i_low;
    assign p_den[0]  = i_den;
    assign p_side[0] = i_side;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [ORIG_BITS:0] t;
        logic [ORIG_BITS:0] d;
        logic               ge;
        assign t  = {p_rem[k], p_low[k][ORIG_BITS-1]};
        assign d  = t - {1'b0, p_den[k]};
        assign ge = t >= {1'b0, p_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                p_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                p_v[k+1] <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                p_rem[k+1]  <= ge ? d[ORIG_BITS-1:0] : t[ORIG_BITS-1:0];
                p_low[k+1]  <= {p_low[k][ORIG_BITS-2:0], ge};
                p_den[k+1]  <= p_den[k];
                p_side[k+1] <= p_side[k];
            end
        end
    end

    assign o_valid = p_v[DIV_STAGES];
    assign o_quot  = p_low[DIV_STAGES];
    assign o_side  = p_side[DIV_STAGES];

endmodule

/* sv/fpr_place.sv */
// Final sizes, anchor offsets and pixel alignment of the placed rectangle.
module fpr_place import fpr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [ORIG_BITS-1:0]         i_quot,
    input  t_side                        i_side,
    output logic                         o_valid,
    output logic signed [POS_BITS-1:0]   o_rect_x,
    output logic signed [POS_BITS-1:0]   o_rect_y,
    output logic [ORIG_BITS-1:0]         o_rect_w,
    output logic [ORIG_BITS-1:0]         o_rect_h
);

    logic                         r3_v, r4_v, r5_v;
    logic [ORIG_BITS-1:0]         r3_sw, r3_sh, r4_sw, r4_sh;
    logic [3:0]                   r3_place;
    logic signed [COORD_BITS-1:0] r3_bx, r3_by, r3_bw, r3_bh, r4_bx, r4_by;
    logic signed [POS_BITS-1:0]   r4_ox, r4_oy, n_ox, n_oy;
    logic signed [POS_BITS-1:0]   r5_x, r5_y;
    logic [ORIG_BITS-1:0]         r5_w, r5_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= i_valid;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    logic signed [COORD_BITS-1:0] hx, hy;
    logic signed [POS_BITS-1:0]   cx, cy, ex, ey;
    logic signed [POS_BITS:0]     sx, sy;

    always_comb begin
        hx = (r3_bw + $signed(COORD_BITS'(r3_bw[COORD_BITS-1]))) >>> 1;
        hy = (r3_bh + $signed(COORD_BITS'(r3_bh[COORD_BITS-1]))) >>> 1;
        cx = (POS_BITS'(hx) - $signed({2'b00, r3_sw[ORIG_BITS-1:1]})) & POS_MASK;
        cy = (POS_BITS'(hy) - $signed({2'b00, r3_sh[ORIG_BITS-1:1]})) & POS_MASK;
        ex = POS_BITS'(r3_bw) - $signed({2'b00, r3_sw});
        ey = POS_BITS'(r3_bh) - $signed({2'b00, r3_sh});
        case (r3_place)
            PLACE_N:      begin n_ox = cx; n_oy = '0; end
            PLACE_NE:     begin n_ox = ex; n_oy = '0; end
            PLACE_E:      begin n_ox = ex; n_oy = cy; end
            PLACE_SE:     begin n_ox = ex; n_oy = ey; end
            PLACE_S:      begin n_ox = cx; n_oy = ey; end
            PLACE_SW:     begin n_ox = '0; n_oy = ey; end
            PLACE_W:      begin n_ox = '0; n_oy = cy; end
            PLACE_CENTER: begin n_ox = cx; n_oy = cy; end
            default:      begin n_ox = '0; n_oy = '0; end
        endcase
        sx = (POS_BITS+1)'(r4_bx) + (POS_BITS+1)'(r4_ox);
        sy = (POS_BITS+1)'(r4_by) + (POS_BITS+1)'(r4_oy);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_side.use_div && i_side.div_to_h) begin
                r3_sw <= i_side.fix_w;
                r3_sh <= i_quot;
            end else if (i_side.use_div) begin
                r3_sw <= i_quot;
                r3_sh <= i_side.fix_h;
            end else begin
                r3_sw <= i_side.fix_w;
                r3_sh <= i_side.fix_h;
            end
            r3_place <= i_side.placement;
            r3_bx    <= i_side.bx;
            r3_by    <= i_side.by;
            r3_bw    <= i_side.bw;
            r3_bh    <= i_side.bh;
            r4_sw    <= r3_sw;
            r4_sh    <= r3_sh;
            r4_bx    <= r3_bx;
            r4_by    <= r3_by;
            r4_ox    <= n_ox;
            r4_oy    <= n_oy;
            r5_x     <= sx[POS_BITS-1:0] & POS_MASK;
            r5_y     <= sy[POS_BITS-1:0] & POS_MASK;
            r5_w     <= r4_sw & ORIG_MASK;
            r5_h     <= r4_sh & ORIG_MASK;
        end
    end

    assign o_valid  = r5_v;
    assign o_rect_x = r5_x;
    assign o_rect_y = r5_y;
    assign o_rect_w = r5_w;
    assign o_rect_h = r5_h;

endmodule
